@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on the rising clock, ignored while reset is low.
`define ASSERT_CLK(label, clk_s, rst_s, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("port property violated");

// Property that holds in the cycle after its trigger.
`define ASSERT_NEXT(label, clk_s, rst_s, trig, prop) \
    `ASSERT_CLK(label, clk_s, rst_s, (trig) |=> (prop))

`endif

@@ src/ssw_pkg.sv @@
// Package with the constants and types of the signed word sorter.
`timescale 1ns / 1ps
`default_nettype none

package ssw_pkg;

    localparam int CAPACITY = 64;
    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // Control that the top level broadcasts to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    // What one cell shows to its neighbors.
    typedef struct packed {
        word_t value;
        logic  valid;
        logic  gt;
    } cell_link_t;

endpackage

`default_nettype wire

@@ src/ssw_cell.sv @@
// One cell of the sorting chain: holds a word and inserts or shifts it.
`timescale 1ns / 1ps
`default_nettype none

module ssw_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ssw_pkg::cell_ctrl_t ctrl,
    input  ssw_pkg::word_t     new_value,
    input  ssw_pkg::cell_link_t left_link,
    input  ssw_pkg::cell_link_t right_link,
    output ssw_pkg::cell_link_t own_link
);
    import ssw_pkg::*;

    word_t value_reg;
    word_t value_next;
    logic  valid_reg;
    logic  valid_next;
    logic  gt;

    // An empty cell counts as larger than any word, so the chain stays sorted.
    assign gt = !valid_reg || (value_reg > new_value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = right_link.value;
            valid_next = right_link.valid;
        end
        else if (ctrl.insert && gt)
        begin
            value_next = left_link.gt ? left_link.value : new_value;
            valid_next = valid_reg || left_link.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign own_link.value = value_reg;
    assign own_link.valid = valid_reg;
    assign own_link.gt    = gt;

endmodule

`default_nettype wire

@@ src/sort_signed_words_ascending_unit.sv @@
// Top level of the signed word sorter: cell chain and load/drain control.
// Usage:
// The input channel (in_valid, in_stall, sample_value, last_item) takes one
// word per cycle while loading. Each word is inserted at once into a chain
// of CAPACITY cells that is kept in ascending signed order. The word with
// last_item set closes the set; it is stored too if there is room.
// Words beyond CAPACITY are dropped and overflow_seen is set on every
// result of that set.
// In the cycle after the closing word is taken, the output channel (out_valid,
// out_stall, sorted_value, last_result, overflow_seen) gives the set smallest
// first, one word per cycle while out_stall is low, as the chain shifts toward
// cell 0. last_result marks the largest word.
// in_stall is high from the cycle after the closing word until the last
// result is taken; loading resumes on the next cycle.
// While out_stall is high the chain holds and the result does not change.
// Reset empties the chain, clears the drop flag and returns to loading.
`timescale 1ns / 1ps
`default_nettype none

module sort_signed_words_ascending_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ssw_pkg::word_t sample_value,
    input  logic           last_item,
    output logic           out_valid,
    input  logic           out_stall,
    output ssw_pkg::word_t sorted_value,
    output logic           last_result,
    output logic           overflow_seen
);
    import ssw_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic       drop_reg;
    logic       drop_next;
    cell_ctrl_t ctrl;
    logic       in_accept;
    logic       out_accept;
    logic       full;

    cell_link_t links [CAPACITY];
    cell_link_t left_of [CAPACITY];
    cell_link_t right_of [CAPACITY];

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign full       = links[CAPACITY-1].valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && last_item)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_accept && last_result)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
            end
            ST_DRAIN:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        drop_next = drop_reg;
        if (in_accept && full)
        begin
            drop_next = 1'b1;
        end
        else if (out_accept && last_result)
        begin
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drop_reg  <= drop_next;
        end
    end

    assign ctrl.insert = in_accept && !full;
    assign ctrl.shift  = out_accept;

    // Cell 0 sees a filled, smaller left neighbor; the last cell an empty right one.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_of[gi] = '{value: '0, valid: 1'b1, gt: 1'b0};
            end
            else
            begin : g_mid_left
                assign left_of[gi] = links[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_of[gi] = '{value: '0, valid: 1'b0, gt: 1'b1};
            end
            else
            begin : g_mid_right
                assign right_of[gi] = links[gi+1];
            end

            ssw_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_value  (sample_value),
                .left_link  (left_of[gi]),
                .right_link (right_of[gi]),
                .own_link   (links[gi])
            );
        end
    endgenerate

    assign sorted_value  = links[0].value;
    assign last_result   = !links[1].valid;
    assign overflow_seen = drop_reg;

endmodule

`default_nettype wire

@@ src/ssw_checker.sv @@
// Port-level checker for the sorter and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ssw_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_stall,
    input  wire logic           last_item,
    input  wire logic           out_valid,
    input  wire logic           out_stall,
    input  wire ssw_pkg::word_t sorted_value,
    input  wire logic           last_result,
    input  wire logic           overflow_seen
);

    // The block never loads and emits in the same cycle.
    `ASSERT_CLK(a_load_xor_emit, clk, rst_n, !in_stall |-> !out_valid)

    // A closing word starts the results on the next cycle.
    `ASSERT_NEXT(a_close_starts, clk, rst_n, in_valid && !in_stall && last_item, out_valid)

    // Once the largest word is taken, loading resumes.
    `ASSERT_NEXT(a_end_reloads, clk, rst_n, out_valid && !out_stall && last_result, !in_stall)

    // A stalled result holds its value and flags.
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(sorted_value) && $stable(last_result) && $stable(overflow_seen))

endmodule

bind sort_signed_words_ascending_unit ssw_checker u_ssw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .last_item     (last_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sorted_value  (sorted_value),
    .last_result   (last_result),
    .overflow_seen (overflow_seen)
);

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the signed word sorter: random sets, stalls, result check.
`timescale 1ns / 1ps

module tb_top;

    import ssw_pkg::*;

    localparam int    TARGET_WORDS = 400;
    localparam int    CYCLE_LIMIT  = 300000;
    localparam int    HOLD_CYCLES  = 400;
    localparam word_t WORD_MAX     = 32'sh7FFFFFFF;
    localparam word_t WORD_MIN     = 32'sh80000000;

    typedef enum int {
        VALS_ANY,
        VALS_CLOSE,
        VALS_EDGE
    } value_mix_t;

    typedef struct packed {
        word_t value;
        logic  last;
        logic  ovf;
    } sorted_word_t;

    class sort_scoreboard;
        sorted_word_t expected_q[$];
        word_t        open_set[$];
        bit           dropped;
        int           errors;
        int           checked;
        int           sets_closed;
        int           overflow_sets;

        function void note_word(word_t value, bit closes);
            word_t        key;
            int           j;
            sorted_word_t entry;
            if (open_set.size() < CAPACITY)
                open_set.push_back(value);
            else
                dropped = 1'b1;
            if (closes)
            begin
                for (int i = 1; i < open_set.size(); i++)
                begin
                    key = open_set[i];
                    j = i;
                    while (j > 0 && open_set[j-1] > key)
                    begin
                        open_set[j] = open_set[j-1];
                        j--;
                    end
                    open_set[j] = key;
                end
                for (int i = 0; i < open_set.size(); i++)
                begin
                    entry.value = open_set[i];
                    entry.last  = (i == open_set.size() - 1);
                    entry.ovf   = dropped;
                    expected_q.push_back(entry);
                end
                sets_closed++;
                if (dropped)
                    overflow_sets++;
                open_set.delete();
                dropped = 1'b0;
            end
        endfunction

        function void check_result(word_t value, bit last, bit ovf);
            sorted_word_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: expected none, actual value %0d last %0b ovf %0b",
                         $time, value, last, ovf);
                return;
            end
            want = expected_q.pop_front();
            if (value !== want.value)
            begin
                errors++;
                $display("%0t: sorted_value expected %0d actual %0d", $time, want.value, value);
            end
            if (last !== want.last)
            begin
                errors++;
                $display("%0t: last_result expected %0b actual %0b", $time, want.last, last);
            end
            if (ovf !== want.ovf)
            begin
                errors++;
                $display("%0t: overflow_seen expected %0b actual %0b", $time, want.ovf, ovf);
            end
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    word_t sample_value = '0;
    logic  last_item = 1'b0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    word_t sorted_value;
    logic  last_result;
    logic  overflow_seen;

    sort_scoreboard sb;
    bit             tx_idle = 1'b0;
    bit             rx_idle = 1'b0;
    int             hold_req = 0;

    sort_signed_words_ascending_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_value  (sample_value),
        .last_item     (last_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sorted_value  (sorted_value),
        .last_result   (last_result),
        .overflow_seen (overflow_seen)
    );

    always #4 clk = ~clk;

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic word_t pick_value(value_mix_t mix);
        case (mix)
            VALS_CLOSE: return word_t'($urandom_range(0, 6)) - 3;
            VALS_EDGE:
            begin
                case ($urandom_range(0, 5))
                    0: return WORD_MIN;
                    1: return WORD_MIN + 1;
                    2: return WORD_MAX;
                    3: return WORD_MAX - 1;
                    4: return 0;
                    default: return -1;
                endcase
            end
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic send_word(input word_t value, input bit closes);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= value;
        last_item    <= closes;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(value, closes);
    endtask

    task automatic send_set(input int count, input value_mix_t mix);
        for (int i = 0; i < count; i++)
            send_word(pick_value(mix), i == count - 1);
    endtask

    // Result side: checks every accepted word and chooses the next stall.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(sorted_value, last_result, overflow_seen);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = rx_idle ? pick_gap() : 0;
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        int         words;
        int         size;
        int         r;
        bit         pressure_done;
        value_mix_t mix;
        sb = new();
        words = 0;
        pressure_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-word sets at both ends of the range, then a set that spans it.
        send_word(WORD_MAX, 1'b1);
        send_word(WORD_MIN, 1'b1);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b0);
        send_word(WORD_MAX, 1'b0);
        send_word(WORD_MIN, 1'b1);
        // Duplicates must all come out.
        send_word(5, 1'b0);
        send_word(-5, 1'b0);
        send_word(5, 1'b0);
        send_word(5, 1'b1);
        send_word(-7, 1'b0);
        send_word(-7, 1'b1);
        // Words with and without the sign bit set, then a set sent in descending order.
        send_word(32'sh80000001, 1'b0);
        send_word(32'sh7FFFFFFE, 1'b0);
        send_word(32'sh40000000, 1'b0);
        send_word(32'shC0000000, 1'b0);
        send_word(-1, 1'b1);
        send_word(100, 1'b0);
        send_word(50, 1'b0);
        send_word(-50, 1'b0);
        send_word(-100, 1'b1);

        while (words < TARGET_WORDS)
        begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 65)
                size = $urandom_range(1, 8);
            else if (r < 82)
                size = $urandom_range(9, 40);
            else if (r < 90)
                size = $urandom_range(41, 63);
            else if (r < 95)
                size = CAPACITY;
            else
                size = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            mix = value_mix_t'($urandom_range(0, 2));
            send_set(size, mix);
            words += (size < CAPACITY) ? size : CAPACITY;

            // Hold the result side off while a full set drains, so the next
            // set backs up against in_stall.
            if (!pressure_done && words > 150)
            begin
                send_set(CAPACITY, VALS_ANY);
                hold_req = HOLD_CYCLES;
                send_set(CAPACITY + 3, VALS_CLOSE);
                words += 2 * CAPACITY;
                pressure_done = 1'b1;
            end
        end
        in_valid <= 1'b0;
        rx_idle = 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 10) @(posedge clk);

        $display("Closed %0d sets and checked %0d sorted words; %0d sets dropped words.",
                 sb.sets_closed, sb.checked, sb.overflow_sets);
        $display("Set sizes ran from 1 word to past capacity, with idle gaps and a long hold-off.");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
